>>> design/pidz_pkg.sv
// shared types and constants of the pid position loop
package pidz_pkg;

  // payload and register types
  typedef logic        [14:0] pos_t;
  typedef logic signed [15:0] pwr_t;
  typedef logic signed [23:0] gain_t;
  typedef logic signed [15:0] err_t;
  typedef logic signed [31:0] acc_t;
  typedef logic signed [30:0] term_t;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_KP         = 3'd0,
    CFG_KI         = 3'd1,
    CFG_KD         = 3'd2,
    CFG_KF         = 3'd3,
    CFG_IZONE      = 3'd4,
    CFG_MIN_OUTPUT = 3'd5,
    CFG_MAX_OUTPUT = 3'd6,
    CFG_LOWER_STOP = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // product scaling: q8.16 gain times q7.8 value down to q.15
  localparam int unsigned ProdShift = 9;

  // reset values
  localparam pwr_t MinOutputRst = 16'sh8000;
  localparam pwr_t MaxOutputRst = 16'sh7fff;
  localparam pos_t LowerStopRst = 15'd2688;

  // full set of configuration registers
  typedef struct packed {
    gain_t kp;
    gain_t ki;
    gain_t kd;
    gain_t kf;
    pos_t  izone;
    pwr_t  min_output;
    pwr_t  max_output;
    pos_t  lower_stop;
  } cfg_t;

endpackage

>>> design/pidz_in_if.sv
// request channel carrying one control tick (setpoint and position sample)
interface pidz_in_if;
  import pidz_pkg::*;

  logic valid;
  logic ready;
  pos_t target;
  pos_t measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

>>> design/pidz_out_if.sv
// request channel carrying one drive power result
interface pidz_out_if;
  import pidz_pkg::*;

  logic valid;
  logic ready;
  pwr_t power;
  logic stopped_at_floor;

  modport source (output valid, output power, output stopped_at_floor, input ready);
  modport sink   (input valid, input power, input stopped_at_floor, output ready);
endinterface

>>> design/pidz_cfg_regs.sv
// configuration register file of the pid position loop
module pidz_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pidz_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [pidz_pkg::CfgDataW-1:0]        cfg_data_i,
  output pidz_pkg::cfg_t                       cfg_o
);
  import pidz_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KP:         cfg_d.kp         = gain_t'(cfg_data_i);
        CFG_KI:         cfg_d.ki         = gain_t'(cfg_data_i);
        CFG_KD:         cfg_d.kd         = gain_t'(cfg_data_i);
        CFG_KF:         cfg_d.kf         = gain_t'(cfg_data_i);
        CFG_IZONE:      cfg_d.izone      = cfg_data_i[14:0];
        CFG_MIN_OUTPUT: cfg_d.min_output = cfg_data_i[15:0];
        CFG_MAX_OUTPUT: cfg_d.max_output = cfg_data_i[15:0];
        CFG_LOWER_STOP: cfg_d.lower_stop = cfg_data_i[14:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp         <= '0;
      cfg_q.ki         <= '0;
      cfg_q.kd         <= '0;
      cfg_q.kf         <= '0;
      cfg_q.izone      <= '0;
      cfg_q.min_output <= MinOutputRst;
      cfg_q.max_output <= MaxOutputRst;
      cfg_q.lower_stop <= LowerStopRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/pidz_integ.sv
// integrator with integral zone clearing and 32-bit saturation
module pidz_integ (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            in_zone_i,
  input  pidz_pkg::term_t inc_i,
  output pidz_pkg::acc_t  acc_next_o
);
  import pidz_pkg::*;

  acc_t               acc_q;
  acc_t               acc_d;
  logic signed [32:0] sum_w;
  acc_t               sat_w;

  // accumulate and saturate
  always_comb begin
    sum_w = 33'(acc_q) + 33'(inc_i);
    priority if (sum_w[32:31] == 2'b01) begin
      sat_w = 32'sh7fff_ffff;
    end else if (sum_w[32:31] == 2'b10) begin
      sat_w = 32'sh8000_0000;
    end else begin
      sat_w = sum_w[31:0];
    end
    acc_d = in_zone_i ? sat_w : '0;
  end

  // integrator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_next_o = acc_d;

`ifndef SYNTH
  // outside the zone a step clears the integrator
  a_zone_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !in_zone_i |=> acc_q == '0)
    else $error("integrator not cleared outside zone");

  // inside the zone a step takes the saturated sum
  a_zone_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && in_zone_i |=> acc_q == $past(sat_w))
    else $error("integrator did not take the saturated sum");

  // no step leaves the integrator alone
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(acc_q))
    else $error("integrator moved without a step");
`endif

endmodule

>>> design/pid_position_loop_with_izone.sv
// pid position loop: a request passes input, product, integrator and output registers
// one request per cycle unless stalled; four stages (input, products, integrator, clamp)
// integrator and last error are the only feedback paths, each closing within its stage
// each stage only holds when the stage after it is full and stalled
// reset clears stage valids, integrator, last error and loads register defaults
module pid_position_loop_with_izone (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pidz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pidz_pkg::CfgDataW-1:0] cfg_data_i,
  pidz_in_if.sink                       in_ch,
  pidz_out_if.source                    out_ch
);
  import pidz_pkg::*;

  cfg_t cfg;

  // stage valids and handshake
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;
  logic acc_in, adv1, adv2, adv3;

  // stage 1 payload
  pos_t tgt1_q, meas1_q;
  err_t err1, mag1, last_err_q;
  logic signed [16:0] diff1;
  logic in_zone1, below1;
  logic signed [39:0] prod_p, prod_i, prod_f;
  logic signed [40:0] prod_d;

  // stage 2 payload
  term_t p2_q, i2_q, f2_q;
  acc_t  d2_q;
  logic  zone2_q, below2_q;
  acc_t  int_next;
  logic signed [33:0] pdf2;

  // stage 3 payload
  logic signed [33:0] pdf3_q;
  acc_t  int3_q;
  logic  below3_q;
  logic signed [34:0] sum3, lo3, clamp3;
  logic  blocked3;
  pwr_t  power3;

  // output register
  pwr_t  power_q;
  logic  flag_q;

  pidz_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ready chain: a stage takes a request when empty or when it passes on
  assign rdyo   = !vo_q || out_ch.ready;
  assign rdy3   = !v3_q || rdyo;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign acc_in = in_ch.valid && rdy1;
  assign adv1   = v1_q && rdy2;
  assign adv2   = v2_q && rdy3;
  assign adv3   = v3_q && rdyo;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_ch.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // stage 1: error, zone test and the four products
  always_comb begin
    err1     = err_t'({1'b0, tgt1_q}) - err_t'({1'b0, meas1_q});
    mag1     = err1[15] ? -err1 : err1;
    diff1    = 17'(err1) - 17'(last_err_q);
    in_zone1 = (cfg.izone == '0) || ({1'b0, cfg.izone} >= mag1);
    below1   = meas1_q < cfg.lower_stop;
    prod_p   = cfg.kp * err1;
    prod_i   = cfg.ki * err1;
    prod_d   = cfg.kd * diff1;
    prod_f   = cfg.kf * err_t'({1'b0, tgt1_q});
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      tgt1_q  <= in_ch.target;
      meas1_q <= in_ch.measured;
    end
  end

  // last error advances with each request leaving stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (adv1) begin
      last_err_q <= err1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      p2_q     <= prod_p[39:ProdShift];
      i2_q     <= prod_i[39:ProdShift];
      d2_q     <= prod_d[40:ProdShift];
      f2_q     <= prod_f[39:ProdShift];
      zone2_q  <= in_zone1;
      below2_q <= below1;
    end
  end

  // stage 2: integrator step and sum of the other terms
  pidz_integ u_integ (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (adv2),
    .in_zone_i  (zone2_q),
    .inc_i      (i2_q),
    .acc_next_o (int_next)
  );

  assign pdf2 = 34'(p2_q) + 34'(d2_q) + 34'(f2_q);

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pdf3_q   <= pdf2;
      int3_q   <= int_next;
      below3_q <= below2_q;
    end
  end

  // stage 3: total, clamp and lower stop
  always_comb begin
    sum3     = 35'(pdf3_q) + 35'(int3_q);
    lo3      = (sum3 < 35'(cfg.min_output)) ? 35'(cfg.min_output) : sum3;
    clamp3   = (lo3 > 35'(cfg.max_output)) ? 35'(cfg.max_output) : lo3;
    blocked3 = below3_q && clamp3[34];
    power3   = blocked3 ? '0 : clamp3[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      power_q <= power3;
      flag_q  <= blocked3;
    end
  end

  assign out_ch.valid            = vo_q;
  assign out_ch.power            = power_q;
  assign out_ch.stopped_at_floor = flag_q;

`ifndef SYNTH
  // a blocked drive always reads as zero power
  a_block_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && flag_q |-> power_q == '0)
    else $error("blocked drive with nonzero power");

  // unblocked power never exceeds the upper limit
  a_max_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && !flag_q |-> power_q <= cfg.max_output)
    else $error("power above max_output");

  // occupancy only changes with a request in or a result out
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_in && !(vo_q && out_ch.ready)
    |=> $countones({v1_q, v2_q, v3_q, vo_q}) == $past($countones({v1_q, v2_q, v3_q, vo_q})))
    else $error("pipeline lost or invented a request");
`endif

endmodule

>>> test/tb_top.sv
// self-checking testbench of the pid position loop with integral zone
`timescale 1ns / 100ps

module tb_top;
  import pidz_pkg::*;

  localparam int unsigned PipeLatency   = 3;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomPhases  = 10;
  localparam int unsigned TicksPerPhase = 185;
  localparam gain_t       GainHi        = 24'sh7fffff;
  localparam gain_t       GainLo        = 24'sh800000;
  localparam pos_t        PosTop        = 15'h7fff;
  localparam pos_t        ScaleTop      = 15'd25600;

  // flavours of register settings for the random phases
  typedef enum int unsigned {
    SET_TYPICAL   = 0,
    SET_HIGH_EDGE = 1,
    SET_LOW_EDGE  = 2,
    SET_WILD      = 3
  } settings_kind_e;

  // receiver back-pressure patterns
  typedef enum int unsigned {
    RX_STREAM = 0,
    RX_COIN   = 1,
    RX_SPARSE = 2,
    RX_RUNS   = 3
  } rx_mode_e;

  typedef struct {
    pos_t target;
    pos_t measured;
  } tick_t;

  typedef struct {
    pwr_t power;
    logic stopped;
  } drive_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  pidz_in_if  in_bus ();
  pidz_out_if out_bus ();

  pid_position_loop_with_izone u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_bus),
    .out_ch     (out_bus)
  );

  always #1 clk_i = ~clk_i;

  // shadow registers and loop state of the predictor
  gain_t kp_q        = '0;
  gain_t ki_q        = '0;
  gain_t kd_q        = '0;
  gain_t kf_q        = '0;
  pos_t  izone_q     = '0;
  pwr_t  min_out_q   = MinOutputRst;
  pwr_t  max_out_q   = MaxOutputRst;
  pos_t  stop_q      = LowerStopRst;
  acc_t  integ_q     = '0;
  err_t  last_err_q  = '0;

  tick_t  tick_pending_q[$];
  drive_t drive_expected_q[$];

  int unsigned error_count    = 0;
  int unsigned ticks_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned blocked_seen   = 0;
  int unsigned integ_sat_hits = 0;
  int unsigned settings_count = 0;

  // one control tick of the loop, advancing integrator and last error
  function automatic drive_t predict_drive(pos_t target, pos_t measured);
    longint tgt, meas, err, mag, zone, integ, p_term, d_term, f_term, sum;
    longint kp_l, ki_l, kd_l, kf_l, last_l, lo_l, hi_l, stop_l;
    drive_t res;
    tgt    = target;
    meas   = measured;
    kp_l   = kp_q;
    ki_l   = ki_q;
    kd_l   = kd_q;
    kf_l   = kf_q;
    last_l = last_err_q;
    lo_l   = min_out_q;
    hi_l   = max_out_q;
    stop_l = stop_q;
    zone   = izone_q;
    err    = tgt - meas;
    mag    = (err < 0) ? -err : err;

    p_term = (kp_l * err) >>> ProdShift;

    // integrate inside the zone, clear outside it
    if (mag <= zone || zone == 0) begin
      integ = longint'(integ_q) + ((err * ki_l) >>> ProdShift);
      if (integ > 64'sd2147483647) begin
        integ = 64'sd2147483647;
        integ_sat_hits++;
      end else if (integ < -64'sd2147483648) begin
        integ = -64'sd2147483648;
        integ_sat_hits++;
      end
    end else begin
      integ = 0;
    end
    integ_q = integ[31:0];

    d_term     = ((err - last_l) * kd_l) >>> ProdShift;
    last_err_q = err[15:0];
    f_term     = (tgt * kf_l) >>> ProdShift;

    // clamp low first, then high, so an inverted range yields the maximum
    sum = p_term + integ + d_term + f_term;
    if (sum < lo_l) sum = lo_l;
    if (sum > hi_l) sum = hi_l;

    res.stopped = (meas < stop_l) && (sum < 0);
    res.power   = res.stopped ? '0 : sum[15:0];
    return res;
  endfunction

  // input sender: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  tick_t       next_tick;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid    <= 1'b0;
      in_bus.target   <= '0;
      in_bus.measured <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        drive_expected_q.push_back(predict_drive(in_bus.target, in_bus.measured));
        ticks_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left == 0 && tick_pending_q.size() != 0) begin
          next_tick = tick_pending_q.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.target   <= next_tick.target;
          in_bus.measured <= next_tick.measured;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_bus.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // result receiver with its own stall pattern, and the checker
  rx_mode_e    rx_mode   = RX_STREAM;
  int unsigned mode_left = 0;
  int unsigned run_left  = 0;
  logic        run_high  = 1'b1;
  drive_t      want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (out_bus.stopped_at_floor === 1'b1) blocked_seen++;
        if (drive_expected_q.size() == 0) begin
          $error("result with no tick waiting: power %0d, stopped_at_floor %0b",
                 out_bus.power, out_bus.stopped_at_floor);
          error_count++;
        end else begin
          want = drive_expected_q.pop_front();
          if (out_bus.power !== want.power) begin
            $error("power: expected %0d, actual %0d", want.power, out_bus.power);
            error_count++;
          end
          if (out_bus.stopped_at_floor !== want.stopped) begin
            $error("stopped_at_floor: expected %0b, actual %0b",
                   want.stopped, out_bus.stopped_at_floor);
            error_count++;
          end
        end
      end

      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(RX_STREAM, RX_RUNS));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STREAM: begin
          out_bus.ready <= 1'b1;
        end
        RX_COIN: begin
          out_bus.ready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          out_bus.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (run_left == 0) begin
            run_high = ~run_high;
            run_left = $urandom_range(1, 25);
          end
          run_left--;
          out_bus.ready <= run_high;
        end
      endcase
    end
  end

  // watchdog on cycles with no request moving on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no request moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, drive_expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // register write, shadowed for the predictor
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_KP:         kp_q      = data;
      CFG_KI:         ki_q      = data;
      CFG_KD:         kd_q      = data;
      CFG_KF:         kf_q      = data;
      CFG_IZONE:      izone_q   = data[14:0];
      CFG_MIN_OUTPUT: min_out_q = data[15:0];
      CFG_MAX_OUTPUT: max_out_q = data[15:0];
      default:        stop_q    = data[14:0];
    endcase
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(CFG_KP, CfgDataW'(s.kp));
    write_reg(CFG_KI, CfgDataW'(s.ki));
    write_reg(CFG_KD, CfgDataW'(s.kd));
    write_reg(CFG_KF, CfgDataW'(s.kf));
    write_reg(CFG_IZONE, CfgDataW'(s.izone));
    write_reg(CFG_MIN_OUTPUT, CfgDataW'(s.min_output));
    write_reg(CFG_MAX_OUTPUT, CfgDataW'(s.max_output));
    write_reg(CFG_LOWER_STOP, CfgDataW'(s.lower_stop));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  // wait until every queued tick went in and every result came out
  task automatic drain();
    while (tick_pending_q.size() != 0 || in_bus.valid || drive_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic queue_tick(int unsigned target, int unsigned measured);
    tick_t t;
    t.target   = pos_t'(target);
    t.measured = pos_t'(measured);
    tick_pending_q.push_back(t);
  endtask

  function automatic cfg_t pick_settings(settings_kind_e kind);
    cfg_t s;
    case (kind)
      SET_HIGH_EDGE: begin
        s.kp = GainHi;  s.ki = GainHi;  s.kd = GainLo;  s.kf = GainHi;
        s.izone = '0;
        s.min_output = MinOutputRst;
        s.max_output = MaxOutputRst;
        s.lower_stop = PosTop;
      end
      SET_LOW_EDGE: begin
        s.kp = GainLo;  s.ki = GainLo;  s.kd = GainHi;  s.kf = GainLo;
        s.izone = PosTop;
        s.min_output = MaxOutputRst;
        s.max_output = MinOutputRst;
        s.lower_stop = '0;
      end
      SET_WILD: begin
        s.kp = gain_t'($urandom);
        s.ki = gain_t'($urandom);
        s.kd = gain_t'($urandom);
        s.kf = gain_t'($urandom);
        s.izone = pos_t'($urandom_range(0, 25600));
        s.min_output = pwr_t'($urandom);
        s.max_output = pwr_t'($urandom);
        s.lower_stop = pos_t'($urandom);
      end
      default: begin
        s.kp = gain_t'(int'($urandom_range(0, 262144)) - 131072);
        s.ki = gain_t'(int'($urandom_range(0, 32768)) - 16384);
        s.kd = gain_t'(int'($urandom_range(0, 262144)) - 131072);
        s.kf = gain_t'(int'($urandom_range(0, 65536)) - 32768);
        s.izone = pos_t'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(64, 2560));
        s.min_output = pwr_t'(-int'($urandom_range(4000, 32768)));
        s.max_output = pwr_t'($urandom_range(4000, 32767));
        s.lower_stop = pos_t'($urandom_range(0, 5000));
      end
    endcase
    return s;
  endfunction

  // plant-like motion: the position creeps towards a setpoint held for a while
  int goal_pos  = 0;
  int plant_pos = 0;
  int dwell     = 0;

  task automatic queue_random_tick();
    int unsigned pick;
    int          near_stop;
    pick      = $urandom_range(0, 99);
    near_stop = int'(stop_q) + int'($urandom_range(0, 2)) - 1;
    if (pick < 60) begin
      if (dwell == 0) begin
        goal_pos = $urandom_range(0, 25600);
        dwell    = $urandom_range(5, 40);
      end
      dwell--;
      plant_pos = plant_pos + (goal_pos - plant_pos) / 4 + int'($urandom_range(0, 64)) - 32;
      if (plant_pos < 0) plant_pos = 0;
      if (plant_pos > 25600) plant_pos = 25600;
      queue_tick(goal_pos, plant_pos);
    end else if (pick < 85) begin
      queue_tick($urandom_range(0, 32767), $urandom_range(0, 32767));
    end else begin
      case ($urandom_range(0, 3))
        0: queue_tick(0, ScaleTop);
        1: queue_tick(PosTop, 0);
        2: queue_tick($urandom_range(0, 25600), near_stop);
        default: queue_tick(($urandom_range(0, 1) == 1) ? PosTop : 0,
                            ($urandom_range(0, 1) == 1) ? PosTop : 0);
      endcase
    end
  endtask

  cfg_t phase_set;

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: all gains zero so the drive stays at zero
    queue_tick(12800, 1000);
    queue_tick(0, 25600);
    drain();

    // directed ticks with moderate gains and a narrow zone
    phase_set.kp = 24'sd65536;
    phase_set.ki = 24'sd8192;
    phase_set.kd = 24'sd32768;
    phase_set.kf = 24'sd6554;
    phase_set.izone = 15'd1280;
    phase_set.min_output = -16'sd30000;
    phase_set.max_output = 16'sd30000;
    phase_set.lower_stop = LowerStopRst;
    apply_settings(phase_set);
    queue_tick(0, 0);
    queue_tick(25600, 0);          // large error outside the zone
    queue_tick(0, 25600);          // big negative drive above the stop
    queue_tick(0, 1000);           // negative drive below the stop is blocked
    queue_tick(2688, 2688);
    queue_tick(2000, 2687);        // just under the stop
    queue_tick(PosTop, 0);         // inputs beyond full scale
    queue_tick(0, PosTop);
    queue_tick(PosTop, PosTop);
    queue_tick(12800, 12000);      // inside the zone, integrator builds up
    queue_tick(12800, 12100);
    queue_tick(12800, 13500);
    queue_tick(12800, 12800);
    drain();

    // inverted output range with the zone disabled
    phase_set.izone = '0;
    phase_set.min_output = 16'sd1000;
    phase_set.max_output = -16'sd1000;
    apply_settings(phase_set);
    queue_tick(5000, 3000);
    queue_tick(3000, 5000);
    queue_tick(1000, 1500);        // forced negative maximum below the stop
    queue_tick(25600, 25600);
    drain();

    // random phases over a spread of register settings
    for (int unsigned ph = 0; ph < RandomPhases; ph++) begin
      apply_settings(pick_settings(settings_kind_e'(ph % 4)));
      for (int unsigned n = 0; n < TicksPerPhase; n++) begin
        queue_random_tick();
        // in every third phase the sender holds off mid-phase until the pipeline is empty
        if (n == TicksPerPhase / 2 && ph % 3 == 0) drain();
      end
      drain();
    end

    $display("%0d ticks over %0d register settings, %0d results checked",
             ticks_sent, settings_count, results_seen);
    $display("%0d drives blocked at the lower stop, %0d integrator saturations",
             blocked_seen, integ_sat_hits);
    if (error_count == 0 && drive_expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
